[hdl/cc16_pkg.sv]
// cc16_pkg: types, constants and state helpers for the 16-round block cipher
// no dependencies; used by every other file of the block but cc16_checker
`default_nettype none

package cc16_pkg;

    // field and word widths
    localparam int WORD_W    = 32;
    localparam int FIELD_W   = 64;
    localparam int NUM_WORDS = 16;
    localparam int NUM_DATA  = 8;
    localparam int NUM_KEYS  = 4;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_1 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2_3 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_4_5 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_6_7 = 8'd3;

    // fixed words 0..3 of the state
    localparam logic [WORD_W-1:0] INIT_WORD0 = 32'd1145093211;
    localparam logic [WORD_W-1:0] INIT_WORD1 = 32'd1566258456;
    localparam logic [WORD_W-1:0] INIT_WORD2 = 32'd440612657;
    localparam logic [WORD_W-1:0] INIT_WORD3 = 32'd1721837295;

    // rotate amounts, first and second half of a quarter-round
    localparam logic [4:0] ROT_H1_A = 5'd16;
    localparam logic [4:0] ROT_H1_B = 5'd12;
    localparam logic [4:0] ROT_H2_A = 5'd8;
    localparam logic [4:0] ROT_H2_B = 5'd7;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_arr_t;
    typedef logic [NUM_KEYS-1:0][FIELD_W-1:0] key_t;
    typedef logic [NUM_DATA-1:0][FIELD_W-1:0] data_t;

    // what travels beside the working state
    typedef struct packed {
        logic [FIELD_W-1:0] nonce;
        logic [FIELD_W-1:0] block_number;
        data_t              data;
    } payload_t;

    // which half-round a cell performs
    typedef struct packed {
        logic diag;
        logic second;
    } cell_mode_t;

    // rotate left, amount 1..31
    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [4:0] r);
        logic [4:0] rc;
        rc = 5'd0 - r;
        return (v << r) | (v >> rc);
    endfunction

    // initial state from key, nonce and block number
    function automatic word_arr_t build_state(input key_t key,
                                              input logic [FIELD_W-1:0] nonce,
                                              input logic [FIELD_W-1:0] blk);
        word_arr_t s;
        s[0] = INIT_WORD0;
        s[1] = INIT_WORD1;
        s[2] = INIT_WORD2;
        s[3] = INIT_WORD3;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            s[4 + 2*k] = key[k][31:0];
            s[5 + 2*k] = key[k][63:32];
        end
        s[12] = nonce[31:0];
        s[13] = blk[31:0];
        s[14] = nonce[63:32];
        s[15] = blk[63:32];
        return s;
    endfunction

endpackage

`default_nettype wire

[hdl/cc16_if.sv]
// cc16 channel interfaces: block input, block output and register writes
// depends on cc16_pkg
`default_nettype none

interface cc16_in_if;
    import cc16_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] nonce;
    logic [FIELD_W-1:0] block_number;
    logic [FIELD_W-1:0] data_word0;
    logic [FIELD_W-1:0] data_word1;
    logic [FIELD_W-1:0] data_word2;
    logic [FIELD_W-1:0] data_word3;
    logic [FIELD_W-1:0] data_word4;
    logic [FIELD_W-1:0] data_word5;
    logic [FIELD_W-1:0] data_word6;
    logic [FIELD_W-1:0] data_word7;

    modport source (output valid, nonce, block_number, data_word0, data_word1,
                    data_word2, data_word3, data_word4, data_word5, data_word6,
                    data_word7, input ready);
    modport sink   (input valid, nonce, block_number, data_word0, data_word1,
                    data_word2, data_word3, data_word4, data_word5, data_word6,
                    data_word7, output ready);
endinterface

interface cc16_out_if;
    import cc16_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] out_word0;
    logic [FIELD_W-1:0] out_word1;
    logic [FIELD_W-1:0] out_word2;
    logic [FIELD_W-1:0] out_word3;
    logic [FIELD_W-1:0] out_word4;
    logic [FIELD_W-1:0] out_word5;
    logic [FIELD_W-1:0] out_word6;
    logic [FIELD_W-1:0] out_word7;

    modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                    out_word4, out_word5, out_word6, out_word7, input ready);
    modport sink   (input valid, out_word0, out_word1, out_word2, out_word3,
                    out_word4, out_word5, out_word6, out_word7, output ready);
endinterface

interface cc16_cfg_if;
    import cc16_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/chacha16_block_cipher.sv]
// chacha16_block_cipher: top level, key registers, cell chain and output stage
// depends on cc16_pkg, cc16_if, cc16_cell, cc16_out_stage
`default_nettype none

// Encrypts (or decrypts) one 512-bit block per request with the 256-bit key
// held in four 64-bit registers. The rounds run through a chain of
// 4*DOUBLE_ROUNDS cells, each doing half of a column or diagonal round, then
// an output register that applies the keystream; a block passes through each
// cell register and then the output register, and a new block is taken every
// cycle while the chain is not stalled. The whole chain advances together:
// the input is held off only while the output register is full and not being
// taken. Register writes are always accepted and must only happen while no
// block is in flight; an index beyond the four key registers is ignored.
module chacha16_block_cipher #(
    parameter int DOUBLE_ROUNDS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cc16_in_if.sink    plain,
    cc16_out_if.source cipher,
    cc16_cfg_if.sink   cfg
);
    import cc16_pkg::*;

    localparam int NCELLS = 4 * DOUBLE_ROUNDS;

    key_t      key_reg;
    logic      adv;
    logic      out_valid;
    data_t     out_data;
    logic      vld [NCELLS+1];
    word_arr_t st  [NCELLS+1];
    payload_t  pl  [NCELLS+1];

    // key register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_0_1: key_reg[0] <= cfg.data;
                REG_KEY_2_3: key_reg[1] <= cfg.data;
                REG_KEY_4_5: key_reg[2] <= cfg.data;
                REG_KEY_6_7: key_reg[3] <= cfg.data;
                default:     ;
            endcase
        end
    end

    // chain advances unless the output holds an untaken block
    assign adv         = !out_valid || cipher.ready;
    assign plain.ready = adv;

    // chain head
    assign vld[0]             = plain.valid;
    assign st[0]              = build_state(key_reg, plain.nonce, plain.block_number);
    assign pl[0].nonce        = plain.nonce;
    assign pl[0].block_number = plain.block_number;
    assign pl[0].data         = {plain.data_word7, plain.data_word6, plain.data_word5,
                                 plain.data_word4, plain.data_word3, plain.data_word2,
                                 plain.data_word1, plain.data_word0};

    // round cells: column first half, column second half, diagonal halves
    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        cc16_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .mode      (cell_mode_t'(2'(g % 4))),
            .valid_in  (vld[g]),
            .state_in  (st[g]),
            .pl_in     (pl[g]),
            .valid_out (vld[g+1]),
            .state_out (st[g+1]),
            .pl_out    (pl[g+1])
        );
    end

    cc16_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (vld[NCELLS]),
        .state_in  (st[NCELLS]),
        .pl_in     (pl[NCELLS]),
        .key       (key_reg),
        .valid_out (out_valid),
        .data_out  (out_data)
    );

    assign cipher.valid     = out_valid;
    assign cipher.out_word0 = out_data[0];
    assign cipher.out_word1 = out_data[1];
    assign cipher.out_word2 = out_data[2];
    assign cipher.out_word3 = out_data[3];
    assign cipher.out_word4 = out_data[4];
    assign cipher.out_word5 = out_data[5];
    assign cipher.out_word6 = out_data[6];
    assign cipher.out_word7 = out_data[7];

endmodule

`default_nettype wire

[hdl/cc16_cell.sv]
// cc16_cell: one pipeline cell, half of a column or diagonal round
// depends on cc16_pkg
`default_nettype none

module cc16_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire cc16_pkg::cell_mode_t  mode,
    input  wire logic                  valid_in,
    input  wire cc16_pkg::word_arr_t   state_in,
    input  wire cc16_pkg::payload_t    pl_in,
    output logic                       valid_out,
    output cc16_pkg::word_arr_t        state_out,
    output cc16_pkg::payload_t         pl_out
);
    import cc16_pkg::*;

    logic       valid_reg;
    word_arr_t  state_reg;
    word_arr_t  state_next;
    payload_t   pl_reg;
    logic [4:0] rot_a;
    logic [4:0] rot_b;

    assign rot_a = mode.second ? ROT_H2_A : ROT_H1_A;
    assign rot_b = mode.second ? ROT_H2_B : ROT_H1_B;

    // four independent half quarter-rounds on disjoint words
    always_comb
    begin
        logic [1:0]        lb;
        logic [1:0]        lc;
        logic [1:0]        ld;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        state_next = state_in;
        for (int q = 0; q < 4; q++)
        begin
            lb = 2'(q) + (mode.diag ? 2'd1 : 2'd0);
            lc = 2'(q) + (mode.diag ? 2'd2 : 2'd0);
            ld = 2'(q) + (mode.diag ? 2'd3 : 2'd0);
            a = state_in[{2'd0, 2'(q)}];
            b = state_in[{2'd1, lb}];
            c = state_in[{2'd2, lc}];
            d = state_in[{2'd3, ld}];
            a = a + b;
            d = rotl(d ^ a, rot_a);
            c = c + d;
            b = rotl(b ^ c, rot_b);
            state_next[{2'd0, 2'(q)}] = a;
            state_next[{2'd1, lb}]    = b;
            state_next[{2'd2, lc}]    = c;
            state_next[{2'd3, ld}]    = d;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            pl_reg    <= pl_in;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign pl_out    = pl_reg;

endmodule

`default_nettype wire

[hdl/cc16_out_stage.sv]
// cc16_out_stage: keystream finish (xor of original state) and data xor
// into the output register; depends on cc16_pkg
`default_nettype none

module cc16_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid_in,
    input  wire cc16_pkg::word_arr_t  state_in,
    input  wire cc16_pkg::payload_t   pl_in,
    input  wire cc16_pkg::key_t       key,
    output logic                      valid_out,
    output cc16_pkg::data_t           data_out
);
    import cc16_pkg::*;

    logic      valid_reg;
    data_t     data_reg;
    data_t     data_next;
    word_arr_t orig;
    word_arr_t ks;

    // rebuild orig; key stable while blocks in flight is up to the user
    assign orig = build_state(key, pl_in.nonce, pl_in.block_number);
    assign ks   = state_in ^ orig;

    always_comb
    begin
        for (int i = 0; i < NUM_DATA; i++)
            data_next[i] = pl_in.data[i] ^ {ks[2*i + 1], ks[2*i]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[hdl/cc16_checker.sv]
// cc16_checker: port-level assertions for chacha16_block_cipher, with bind
// depends on chacha16_block_cipher port names
`default_nettype none

module cc16_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_word0,
    input wire logic        cfg_ready
);

    // a stalled result stays and holds its first data word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word0))
        else $error("stalled result dropped or changed");

    // input is held off only by a full, untaken output register
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // register writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register write stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind chacha16_block_cipher cc16_checker u_cc16_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (plain.ready),
    .out_valid (cipher.valid),
    .out_ready (cipher.ready),
    .out_word0 (cipher.out_word0),
    .cfg_ready (cfg.ready)
);

`default_nettype wire
